// ===== hdl/mvma_pkg.sv =====
// Shared types and codes of the matrix-vector multiply-accumulate block.
package mvma_pkg;

	localparam int unsigned RegIdxW = 2;

	typedef enum logic [RegIdxW-1:0] {
		REG_ALPHA = 2'd0,
		REG_BETA  = 2'd1,
		REG_ROWS  = 2'd2,
		REG_COLS  = 2'd3
	} cfg_reg_t;

	localparam logic OP_LOAD_X = 1'b0;
	localparam logic OP_MATRIX = 1'b1;

	typedef struct packed {
		logic signed [15:0] alpha_gain;
		logic signed [15:0] beta_gain;
		logic [15:0]        row_count;
		logic [8:0]         column_count;
	} cfg_t;

	// one matrix element, classified by the front end
	typedef struct packed {
		logic signed [15:0] elem;
		logic signed [15:0] xv;
		logic signed [15:0] y;
		logic               last_col;
		logic [15:0]        row_num;
		logic               last_row;
	} op_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [15:0]        row_number;
		logic               saturated;
		logic               last_row;
	} res_t;

endpackage

// ===== hdl/matrix_vector_multiply_accumulate.sv =====
// Fixed-point out = alpha*A*x + beta*y, one result per matrix row. Load the x
// vector first (opcode 0, one element per transfer), then stream A in
// row-major order (opcode 1), with the row's y on its last-column element.
// Input takes one item per cycle while full is low, loads and matrix
// elements alike: the x store has one write and one registered read port,
// and the multiply-accumulate pipeline takes one element per clock unless
// a finished result waits on a full result queue. Operands are signed
// Q8.8; results are signed Q16.16, saturated to 32 bits with a flag.
// Configure only while idle.
module matrix_vector_multiply_accumulate #(
	parameter int MAX_COLS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                push,
	output logic                full,
	input  logic                opcode,
	input  logic signed [15:0]  element_value,
	input  logic signed [15:0]  y_value,
	output logic                empty,
	input  logic                pop,
	output logic signed [31:0]  result_value,
	output logic [15:0]         row_number,
	output logic                saturated,
	output logic                last_row
);
	mvma_pkg::cfg_t cfg_q;

	logic           op_push, op_full, op_empty, op_pop;
	mvma_pkg::op_t  op_in, op_out;
	logic           res_push, res_full;
	mvma_pkg::res_t res_in, res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_gain   <= 16'sd256;
			cfg_q.beta_gain    <= 16'sd0;
			cfg_q.row_count    <= 16'd1;
			cfg_q.column_count <= 9'd1;
		end else if (cfg_write) begin
			case (mvma_pkg::cfg_reg_t'(cfg_index))
				mvma_pkg::REG_ALPHA: cfg_q.alpha_gain   <= cfg_data;
				mvma_pkg::REG_BETA:  cfg_q.beta_gain    <= cfg_data;
				mvma_pkg::REG_ROWS:  cfg_q.row_count    <= cfg_data;
				mvma_pkg::REG_COLS:  cfg_q.column_count <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	mvma_front #(.MAX_COLS(MAX_COLS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.element_value (element_value),
		.y_value       (y_value),
		.op_push       (op_push),
		.op_data       (op_in),
		.op_full       (op_full)
	);

	mvma_fifo #(.W($bits(mvma_pkg::op_t)), .DEPTH(4)) u_op_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.din    (op_in),
		.full   (op_full),
		.pop    (op_pop),
		.dout   (op_out),
		.empty  (op_empty)
	);

	mvma_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.alpha_gain (cfg_q.alpha_gain),
		.beta_gain  (cfg_q.beta_gain),
		.op_empty   (op_empty),
		.op_data    (op_out),
		.op_pop     (op_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_in)
	);

	mvma_fifo #(.W($bits(mvma_pkg::res_t)), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign result_value = res_out.result_value;
	assign row_number   = res_out.row_number;
	assign saturated    = res_out.saturated;
	assign last_row     = res_out.last_row;

endmodule

// ===== hdl/mvma_fifo.sv =====
// Small synchronous queue built from registers.
module mvma_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + AW'(1);
			if (do_pop)
				rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (AW+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (AW+1)'(1);
		end
	end

endmodule

// ===== hdl/mvma_front.sv =====
// Front end: takes items, keeps the x store and positions, issues matrix ops.
module mvma_front #(
	parameter int MAX_COLS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mvma_pkg::cfg_t      cfg,
	input  logic                push,
	output logic                full,
	input  logic                opcode,
	input  logic signed [15:0]  element_value,
	input  logic signed [15:0]  y_value,
	output logic                op_push,
	output mvma_pkg::op_t       op_data,
	input  logic                op_full
);
	localparam int AW = $clog2(MAX_COLS);
	localparam int CW = $clog2(MAX_COLS + 1);

	logic signed [15:0] x_store [MAX_COLS];

	logic [AW-1:0] xload_q, colpos_q;
	logic [15:0]   rowpos_q;

	logic               valid_s1;
	logic signed [15:0] elem_s1, y_s1, xv_s1;
	logic               last_col_s1, last_row_s1;
	logic [15:0]        row_num_s1;

	logic [CW-1:0] cols;
	logic [15:0]   rows;
	logic          accept, load_x, mat;
	logic [AW-1:0] widx, wnext, ridx, cnext;
	logic          last_col, last_row;

	always_comb begin
		if (cfg.column_count == '0)
			cols = CW'(1);
		else if (32'(cfg.column_count) > 32'(MAX_COLS))
			cols = CW'(MAX_COLS);
		else
			cols = CW'(cfg.column_count);
		rows = (cfg.row_count == '0) ? 16'd1 : cfg.row_count;
	end

	assign full   = valid_s1 && op_full;
	assign accept = push && !full;
	assign load_x = accept && (opcode == mvma_pkg::OP_LOAD_X);
	assign mat    = accept && (opcode == mvma_pkg::OP_MATRIX);

	// load index wraps when the column count has shrunk under it
	always_comb begin
		widx  = ((CW+1)'(xload_q) >= (CW+1)'(cols)) ? '0 : xload_q;
		wnext = ((CW+1)'(widx) + (CW+1)'(1) >= (CW+1)'(cols)) ? '0 : widx + AW'(1);
	end

	// positions past the end count as the last column
	always_comb begin
		ridx     = ((CW+1)'(colpos_q) < (CW+1)'(cols)) ? colpos_q : AW'(cols - CW'(1));
		last_col = ((CW+1)'(colpos_q) + (CW+1)'(1) >= (CW+1)'(cols));
		cnext    = last_col ? '0 : colpos_q + AW'(1);
		last_row = (17'(rowpos_q) + 17'd1 >= 17'(rows));
	end

	always_ff @(posedge clk) begin
		if (load_x)
			x_store[widx] <= element_value;
		if (mat) begin
			xv_s1       <= x_store[ridx];
			elem_s1     <= element_value;
			y_s1        <= y_value;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			row_num_s1  <= rowpos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xload_q  <= '0;
			colpos_q <= '0;
			rowpos_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (load_x)
				xload_q <= wnext;
			if (mat) begin
				colpos_q <= cnext;
				if (last_col)
					rowpos_q <= last_row ? 16'd0 : rowpos_q + 16'd1;
			end
			if (mat)
				valid_s1 <= 1'b1;
			else if (valid_s1 && !op_full)
				valid_s1 <= 1'b0;
		end
	end

	assign op_push          = valid_s1;
	assign op_data.elem     = elem_s1;
	assign op_data.xv       = xv_s1;
	assign op_data.y        = y_s1;
	assign op_data.last_col = last_col_s1;
	assign op_data.row_num  = row_num_s1;
	assign op_data.last_row = last_row_s1;

endmodule

// ===== hdl/mvma_back.sv =====
// Back end: multiply-accumulate pipeline, gain scaling and saturation.
module mvma_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] alpha_gain,
	input  logic signed [15:0] beta_gain,
	input  logic               op_empty,
	input  mvma_pkg::op_t      op_data,
	output logic               op_pop,
	input  logic               res_full,
	output logic               res_push,
	output mvma_pkg::res_t     res_data
);
	localparam logic signed [56:0] SatMax = 57'sd2147483647;
	localparam logic signed [56:0] SatMin = -57'sd2147483648;

	logic adv;

	// stage 1: element product
	logic               valid_s1, last_col_s1, last_row_s1;
	logic signed [31:0] prod_s1;
	logic signed [15:0] y_s1;
	logic [15:0]        row_s1;

	// stage 2: row sum, beta*y
	logic               valid_s2, last_row_s2;
	logic signed [47:0] acc_q, sum_s2;
	logic signed [31:0] by_s2;
	logic [15:0]        row_s2;

	// stage 3: partial products of alpha*sum
	logic               valid_s3, last_row_s3;
	logic signed [39:0] ph_s3;
	logic signed [40:0] pl_s3;
	logic signed [31:0] by_s3;
	logic [15:0]        row_s3;

	// stage 4: full alpha*sum
	logic               valid_s4, last_row_s4;
	logic signed [63:0] scaled_s4;
	logic signed [31:0] by_s4;
	logic [15:0]        row_s4;

	logic signed [47:0] acc_next;
	logic signed [56:0] total;
	logic               sat_hi, sat_lo;

	assign adv      = !(valid_s4 && res_full);
	assign op_pop   = adv && !op_empty;
	assign acc_next = acc_q + {{16{prod_s1[31]}}, prod_s1};

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1     <= op_data.elem * op_data.xv;
			y_s1        <= op_data.y;
			last_col_s1 <= op_data.last_col;
			last_row_s1 <= op_data.last_row;
			row_s1      <= op_data.row_num;

			sum_s2      <= acc_next;
			by_s2       <= beta_gain * y_s1;
			row_s2      <= row_s1;
			last_row_s2 <= last_row_s1;

			ph_s3       <= alpha_gain * $signed(sum_s2[47:24]);
			pl_s3       <= alpha_gain * $signed({1'b0, sum_s2[23:0]});
			by_s3       <= by_s2;
			row_s3      <= row_s2;
			last_row_s3 <= last_row_s2;

			scaled_s4   <= $signed({ph_s3, 24'b0}) + {{23{pl_s3[40]}}, pl_s3};
			by_s4       <= by_s3;
			row_s4      <= row_s3;
			last_row_s4 <= last_row_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			acc_q    <= '0;
		end else if (adv) begin
			valid_s1 <= !op_empty;
			valid_s2 <= valid_s1 && last_col_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (valid_s1)
				acc_q <= last_col_s1 ? '0 : acc_next;
		end
	end

	// arithmetic shift right floors, giving Q16.16
	always_comb begin
		total  = {scaled_s4[63], scaled_s4[63:8]} + {{25{by_s4[31]}}, by_s4};
		sat_hi = (total > SatMax);
		sat_lo = (total < SatMin);
	end

	assign res_push              = valid_s4;
	assign res_data.result_value = sat_hi ? 32'sh7fffffff :
	                               sat_lo ? 32'sh80000000 : total[31:0];
	assign res_data.row_number   = row_s4;
	assign res_data.saturated    = sat_hi || sat_lo;
	assign res_data.last_row     = last_row_s4;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the alpha*A*x + beta*y matrix-vector block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_COLS    = 256;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned TAIL_CYCLES = 12;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned ITEM_TARGET = 900;
	localparam int unsigned CALM_AFTER  = 800;
	localparam int unsigned DIR_ROWS    = 29;
	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;

	typedef enum bit {ROW_ITEM, ROW_REG} dir_kind_t;

	typedef struct packed {
		dir_kind_t          kind;
		mvma_pkg::cfg_reg_t sel;
		logic [15:0]        data;
		logic               op;
		logic [15:0]        elem;
		logic [15:0]        y;
		bit                 typed;
		mvma_pkg::res_t     want;
	} dir_row_t;

	// directed rows; typed results only where they follow at a glance
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_LOAD_X, 16'h0100, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'h0200, 16'h0000,
			1'b1, '{32'h0002_0000, 16'd0, 1'b0, 1'b1}},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'h7FFF, 16'h7FFF,
			1'b1, '{32'h007F_FF00, 16'd0, 1'b0, 1'b1}},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'h8000, 16'h8000,
			1'b1, '{32'hFF80_0000, 16'd0, 1'b0, 1'b1}},
		'{ROW_REG,  mvma_pkg::REG_ALPHA, 16'h8000, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_REG,  mvma_pkg::REG_BETA,  16'h7FFF, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_LOAD_X, 16'h7FFF, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'h7FFF, 16'h7FFF,
			1'b1, '{32'h8000_0000, 16'd0, 1'b1, 1'b1}},
		'{ROW_REG,  mvma_pkg::REG_ALPHA, 16'h7FFF, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'h7FFF, 16'h8000,
			1'b1, '{32'h7FFF_FFFF, 16'd0, 1'b1, 1'b1}},
		'{ROW_REG,  mvma_pkg::REG_BETA,  16'h8000, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'h8000, 16'h8000,
			1'b0, '0},
		'{ROW_REG,  mvma_pkg::REG_ROWS,  16'h0003, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_REG,  mvma_pkg::REG_COLS,  16'h0002, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_REG,  mvma_pkg::REG_ALPHA, 16'h0100, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_REG,  mvma_pkg::REG_BETA,  16'h0100, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_LOAD_X, 16'h0180, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_LOAD_X, 16'hFF80, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'h1234, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'hFEDC, 16'h7FFF,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'h8000, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'h7FFF, 16'h8000,
			1'b0, '0},
		// leave a row half done, then shrink columns and rows under it
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'h0001, 16'h0000,
			1'b0, '0},
		'{ROW_REG,  mvma_pkg::REG_COLS,  16'h0001, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_REG,  mvma_pkg::REG_ROWS,  16'h0001, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'h0100, 16'h0100,
			1'b0, '0},
		// zero counts act as one
		'{ROW_REG,  mvma_pkg::REG_COLS,  16'h0000, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_REG,  mvma_pkg::REG_ROWS,  16'h0000, mvma_pkg::OP_LOAD_X, 16'h0000, 16'h0000,
			1'b0, '0},
		'{ROW_ITEM, mvma_pkg::REG_ALPHA, 16'h0000, mvma_pkg::OP_MATRIX, 16'hFFFF, 16'hFFFF,
			1'b0, '0}
	};

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               cfg_write     = 1'b0;
	logic [1:0]         cfg_index     = '0;
	logic [15:0]        cfg_data      = '0;
	logic               push          = 1'b0;
	logic               full;
	logic               opcode        = 1'b0;
	logic signed [15:0] element_value = '0;
	logic signed [15:0] y_value       = '0;
	logic               empty;
	logic               pop           = 1'b0;
	logic signed [31:0] result_value;
	logic [15:0]        row_number;
	logic               saturated;
	logic               last_row;

	matrix_vector_multiply_accumulate dut (
		.clk, .arst_n, .cfg_write, .cfg_index, .cfg_data, .push, .full, .opcode,
		.element_value, .y_value, .empty, .pop, .result_value, .row_number,
		.saturated, .last_row
	);

	always #1 clk = ~clk;

	// predictor state, mirrors the block after reset
	logic signed [15:0] x_vec [MAX_COLS];
	int unsigned        x_fill     = 0;
	int unsigned        col_pos    = 0;
	int unsigned        row_pos    = 0;
	longint             row_sum    = 0;
	logic signed [15:0] gain_alpha = 16'sh0100;
	logic signed [15:0] gain_beta  = 16'sh0000;
	logic [15:0]        row_cfg    = 16'd1;
	logic [8:0]         col_cfg    = 9'd1;

	mvma_pkg::res_t expected_rows [$];
	mvma_pkg::res_t got_row;
	mvma_pkg::res_t want_row;
	int unsigned    items_sent     = 0;
	int unsigned    mismatch_count = 0;
	int unsigned    quiet_cycles   = 0;
	int unsigned    gap_odds       = 4;
	int unsigned    stall_odds     = 4;
	bit             calm           = 1'b0;
	bit             sink_hold_req  = 1'b0;

	function automatic int unsigned eff_columns();
		if (col_cfg == 0)
			return 1;
		return (col_cfg > MAX_COLS) ? MAX_COLS : int'(col_cfg);
	endfunction

	function automatic void gemv_step(input logic op, input logic signed [15:0] e,
			input logic signed [15:0] y, output bit produced, output mvma_pkg::res_t row);
		int unsigned cols, rows, pos, idx;
		longint      total;
		bit          last;
		cols = eff_columns();
		rows = (row_cfg == 0) ? 1 : row_cfg;
		produced = 1'b0;
		row = '0;
		if (op == mvma_pkg::OP_LOAD_X) begin
			idx = (x_fill >= cols) ? 0 : x_fill;
			x_vec[idx] = e;
			x_fill = (idx + 1 >= cols) ? 0 : idx + 1;
			return;
		end
		pos = col_pos;
		row_sum += longint'(e) * longint'(x_vec[(pos < cols) ? pos : cols - 1]);
		if (pos + 1 < cols) begin
			col_pos = pos + 1;
			return;
		end
		// arithmetic shift of a signed value rounds toward minus infinity
		total = ((longint'(gain_alpha) * row_sum) >>> 8) + longint'(gain_beta) * longint'(y);
		row.saturated = 1'b0;
		if (total > SUM_MAX) begin
			total = SUM_MAX;
			row.saturated = 1'b1;
		end else if (total < SUM_MIN) begin
			total = SUM_MIN;
			row.saturated = 1'b1;
		end
		last = (row_pos + 1 >= rows);
		row.result_value = total[31:0];
		row.row_number = row_pos[15:0];
		row.last_row = last;
		produced = 1'b1;
		row_sum = 0;
		col_pos = 0;
		row_pos = last ? 0 : row_pos + 1;
	endfunction

	function automatic logic [15:0] pick_q88();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void report_row(input string what, input mvma_pkg::res_t want,
			input mvma_pkg::res_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s: want value %h row %0d sat %0b last %0b, got value %h row %0d sat %0b last %0b",
				what, want.result_value, want.row_number, want.saturated, want.last_row,
				got.result_value, got.row_number, got.saturated, got.last_row);
	endfunction

	// the write lands at the next edge; the next action lowers cfg_write
	task automatic write_reg(input mvma_pkg::cfg_reg_t sel, input logic [15:0] data);
		cfg_write <= 1'b1;
		cfg_index <= sel;
		cfg_data <= data;
		case (sel)
			mvma_pkg::REG_ALPHA: gain_alpha = data;
			mvma_pkg::REG_BETA:  gain_beta = data;
			mvma_pkg::REG_ROWS:  row_cfg = data;
			mvma_pkg::REG_COLS:  col_cfg = data[8:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic push_item(input logic op, input logic [15:0] elem, input logic [15:0] y,
			input bit typed = 1'b0, input mvma_pkg::res_t want = '0);
		bit             produced;
		mvma_pkg::res_t row;
		cfg_write <= 1'b0;
		push <= 1'b1;
		opcode <= op;
		element_value <= elem;
		y_value <= y;
		@(posedge clk);
		while (full)
			@(posedge clk);
		gemv_step(op, elem, y, produced, row);
		if (produced)
			expected_rows.push_back(typed ? want : row);
		items_sent++;
		if (items_sent >= CALM_AFTER)
			calm = 1'b1;
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			push <= 1'b0;
			opcode <= 1'($urandom);
			element_value <= 16'($urandom);
			y_value <= 16'($urandom);
			repeat ($urandom_range(1, 16))
				@(posedge clk);
		end
	endtask

	// stop sending and let every pending row come out, plus pipeline slack
	task automatic settle();
		push <= 1'b0;
		cfg_write <= 1'b0;
		@(posedge clk);
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
	endtask

	task automatic run_phase(input int unsigned phase_idx);
		bit          pressure;
		bit          big;
		int unsigned cols;
		int unsigned nrows;
		int unsigned width;
		logic [15:0] rows_val;
		pressure = (phase_idx == 2);
		big = (phase_idx == 5);
		settle();
		gap_odds = pressure ? 0 : 4 * $urandom_range(0, 3);
		stall_odds = 4 * $urandom_range(0, 3);
		write_reg(mvma_pkg::REG_ALPHA, pick_q88());
		write_reg(mvma_pkg::REG_BETA, pick_q88());
		case ($urandom_range(0, 5))
			0: rows_val = 16'd0;
			1: rows_val = 16'hFFFF;
			2, 3: rows_val = 16'($urandom_range(1, 6));
			default: rows_val = 16'($urandom);
		endcase
		write_reg(mvma_pkg::REG_ROWS, rows_val);
		if (pressure)
			cols = 1;
		else if (big)
			cols = $urandom_range(256, 511);
		else if ($urandom_range(0, 7) == 0)
			cols = 0;
		else
			cols = $urandom_range(1, 12);
		write_reg(mvma_pkg::REG_COLS, {7'($urandom), 9'(cols)});
		// fill the whole x vector so no unwritten entry is ever read
		for (int unsigned i = 0; i < eff_columns(); i++)
			push_item(mvma_pkg::OP_LOAD_X, pick_q88(), 16'($urandom));
		if (pressure)
			sink_hold_req = 1'b1;
		nrows = pressure ? 150 : big ? 1 : $urandom_range(1, 8);
		for (int unsigned r = 0; r < nrows; r++) begin
			width = eff_columns();
			if (r == nrows - 1 && width > 1 && $urandom_range(0, 4) == 0)
				width = $urandom_range(1, width - 1);
			for (int unsigned c = 0; c < width; c++) begin
				if ($urandom_range(0, 14) == 0)
					push_item(mvma_pkg::OP_LOAD_X, pick_q88(), 16'($urandom));
				push_item(mvma_pkg::OP_MATRIX, pick_q88(), pick_q88());
			end
		end
	endtask

	// result side: random pop stalls, one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 16))
					@(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (pop && !empty) begin
			got_row = '{result_value, row_number, saturated, last_row};
			if (expected_rows.size() == 0) begin
				report_row("unexpected row", '0, got_row);
			end else begin
				want_row = expected_rows.pop_front();
				if (got_row.result_value !== want_row.result_value ||
						got_row.row_number !== want_row.row_number ||
						got_row.saturated !== want_row.saturated ||
						got_row.last_row !== want_row.last_row)
					report_row("row mismatch", want_row, got_row);
			end
		end
	end

	// watchdog: cycles without any transfer or register write
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned phase_idx;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_REG) begin
				if (i == 0 || DIRECTED[i - 1].kind != ROW_REG)
					settle();
				write_reg(DIRECTED[i].sel, DIRECTED[i].data);
			end else begin
				push_item(DIRECTED[i].op, DIRECTED[i].elem, DIRECTED[i].y,
					DIRECTED[i].typed, DIRECTED[i].want);
			end
		end
		phase_idx = 0;
		while (items_sent < ITEM_TARGET) begin
			run_phase(phase_idx);
			phase_idx++;
		end
		settle();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
